[src/nsqrt_pkg.sv]
// ----------------------------------------------------------------------------
// nsqrt_pkg
// shared types and constants for the fixed-point newton square root
// ----------------------------------------------------------------------------
package nsqrt_pkg;

  // width and reset value of the iteration count register
  localparam int unsigned ITER_W = 5;
  localparam logic [ITER_W-1:0] ITER_RESET = 5'd10;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for an input transaction
    ST_DIV,    // one quotient bit per cycle
    ST_UPD,    // guess <= (guess + quotient) / 2
    ST_DONE    // result ready, waiting for the output register
  } nsqrt_state_t;

endpackage

[src/newton_square_root.sv]
// ----------------------------------------------------------------------------
// newton_square_root
// unsigned fixed-point square root by newton iteration on a shared divider
// ----------------------------------------------------------------------------
// sequence: N iterations, N = iteration count, each of which runs the single
//   restoring divider over all DW quotient bits, one per cycle, and then
//   updates the guess; a zero radicand or a zero count goes straight to the
//   result register; the divider is shared by every iteration
// input: no new item is taken until the result of the last one is registered
// reset: synchronous active-low rst_n clears the sequencer and the output valid,
//   and sets the iteration count to 10
// ----------------------------------------------------------------------------
module newton_square_root
  import nsqrt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration: iteration count
  input  logic                                cfg_we,
  input  logic [ITER_W-1:0]                   cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // radicand, zero padded
  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]    out_tdata   // root, zero padded
);

  // dividend is radicand << FRACTION_BITS, so the quotient and guess live here
  localparam int unsigned DW      = VALUE_WIDTH + FRACTION_BITS;
  localparam int unsigned CNT_W   = $clog2(DW);
  localparam int unsigned TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

  nsqrt_state_t state_r, state_nxt;

  logic [ITER_W-1:0]      iter_cfg_r;
  logic [ITER_W-1:0]      iter_r,  iter_nxt;
  logic [VALUE_WIDTH-1:0] v_r,     v_nxt;
  logic [DW-1:0]          dvd_r,   dvd_nxt;   // dividend bits, msb first
  logic [DW-1:0]          rem_r,   rem_nxt;
  logic [DW-1:0]          quo_r,   quo_nxt;
  logic [DW-1:0]          g_r,     g_nxt;     // current guess
  logic [CNT_W-1:0]       cnt_r,   cnt_nxt;   // quotient bits still to go, minus one
  logic [VALUE_WIDTH-1:0] root_r,  root_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [VALUE_WIDTH-1:0] radicand;
  logic                   in_acc;
  logic                   out_free;
  logic [DW-1:0]          divisor;
  logic [DW:0]            trial;
  logic [DW:0]            diff;
  logic                   ge;
  logic [DW:0]            sum;
  logic [VALUE_WIDTH-1:0] start_guess;

  assign radicand  = in_tdata[VALUE_WIDTH-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // result register can take a new value this cycle
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(root_r);

  // guard against a zero divisor, never hit for a nonzero radicand
  assign divisor = (g_r == '0) ? DW'(1) : g_r;

  // restoring division step: shift in the next dividend bit, try subtract
  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  // newton update, the sum keeps its carry
  assign sum = {1'b0, g_r} + {1'b0, quo_r};

  // start guess: half the radicand, at least one lsb
  assign start_guess = ((radicand >> 1) == '0) ? VALUE_WIDTH'(1) : (radicand >> 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (radicand == '0 || iter_cfg_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (iter_r == ITER_W'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    iter_nxt      = iter_r;
    v_nxt         = v_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    g_nxt         = g_r;
    cnt_nxt       = cnt_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          v_nxt    = radicand;
          dvd_nxt  = DW'(radicand) << FRACTION_BITS;
          rem_nxt  = '0;
          quo_nxt  = '0;
          cnt_nxt  = CNT_W'(DW - 1);
          iter_nxt = iter_cfg_r;
          g_nxt    = (radicand == '0) ? '0 : DW'(start_guess);
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], ge};
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_UPD: begin
        g_nxt    = sum[DW:1];
        iter_nxt = iter_r - ITER_W'(1);
        // reload the divider for the next iteration
        dvd_nxt  = DW'(v_r) << FRACTION_BITS;
        rem_nxt  = '0;
        quo_nxt  = '0;
        cnt_nxt  = CNT_W'(DW - 1);
      end
      ST_DONE: begin
        if (out_free) begin
          root_nxt      = g_r[VALUE_WIDTH-1:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iter_cfg_r  <= ITER_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        iter_cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    v_r    <= v_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    g_r    <= g_nxt;
    cnt_r  <= cnt_nxt;
    root_r <= root_nxt;
  end

  // block stays busy after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // divider runs only with a nonzero guess
  a_guess_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> g_r != '0)
    else $error("zero guess in division");

  // restoring invariant: partial remainder below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < divisor)
    else $error("remainder not below divisor");

  // zero radicand skips the iterations and gives zero
  a_zero_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && radicand == '0 |=> state_r == ST_DONE && g_r == '0)
    else $error("zero radicand not short-cut");

endmodule

[test/newton_square_root_tb.sv]
// ----------------------------------------------------------------------------
// newton_square_root_tb
// self-checking bench for the fixed-point newton square root: directed
// radicands at the reset, zero, single and largest iteration counts, then random
// radicands over a sweep of counts, checked against an in-bench predictor
// ----------------------------------------------------------------------------
module newton_square_root_tb;
  import nsqrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned TDATA_W       = ((VALUE_WIDTH + 7) / 8) * 8;
  // the cycle limit leaves plenty of margin over the slowest legal run
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  // receiver stall patterns, picked at random when the pattern counter's low bits wrap
  typedef enum logic [1:0] {
    RX_STEADY,   // always ready
    RX_RANDOM,   // coin flip each cycle
    RX_SPARSE,   // ready only while the low three pattern counter bits equal five
    RX_BLOCKS    // ready and stalled in turn, following pattern counter bit 4
  } rx_pattern_t;

  // one pending root with the radicand that produced it
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] radicand;
    logic [VALUE_WIDTH-1:0] root;
  } root_pair_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [ITER_W-1:0]   cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata   = '0;   // radicand
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;         // root

  root_pair_t          expected_roots[$];
  logic [ITER_W-1:0]   current_iterations = ITER_RESET;
  rx_pattern_t         rx_pattern = RX_STEADY;
  logic [31:0]         pattern_cycle = '0;
  int unsigned         cycle_count   = 0;
  int unsigned         items_sent    = 0;
  int unsigned         roots_checked = 0;
  int unsigned         error_count   = 0;

  newton_square_root #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d roots still pending",
               $realtime, cycle_count, expected_roots.size());
      $display("newton_square_root: mismatch");
      $finish;
    end
  end

  // receiver back-pressure, with stretches of no stalls in between
  always @(posedge clk) begin
    pattern_cycle <= pattern_cycle + 1;
    if (pattern_cycle[6:0] == 7'd0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
    end
    case (rx_pattern)
      RX_STEADY: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (pattern_cycle[2:0] == 3'd5);
      default:   out_tready <= pattern_cycle[4];
    endcase
  end

  // newton root: start from half the radicand (at least one lsb), then
  // guess <= (guess + floor((radicand << FRACTION_BITS) / guess)) / 2,
  // truncating every step; zero radicand gives zero with no division
  function automatic logic [VALUE_WIDTH-1:0] newton_root(
    input logic [VALUE_WIDTH-1:0] radicand,
    input logic [ITER_W-1:0]      iterations
  );
    logic [63:0] guess;
    logic [63:0] dividend;
    logic [63:0] quotient;
    if (radicand == '0) begin
      return '0;
    end
    dividend = 64'(radicand) << FRACTION_BITS;
    guess    = 64'(radicand) >> 1;
    if (guess == 64'd0) begin
      guess = 64'd1;
    end
    for (int k = 0; k < int'(iterations); k++) begin
      // guess never drops to zero for a nonzero radicand
      if (guess == 64'd0) begin
        guess = 64'd1;
      end
      quotient = dividend / guess;
      guess    = (guess + quotient) >> 1;
    end
    return guess[VALUE_WIDTH-1:0];
  endfunction

  // result checker: each output transaction against the oldest expectation
  always @(posedge clk) begin : check_roots
    root_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected root, expected none, actual %h",
                 $realtime, out_tdata);
        error_count <= error_count + 1;
      end else begin
        want = expected_roots.pop_front();
        roots_checked <= roots_checked + 1;
        if (out_tdata !== TDATA_W'(want.root)) begin
          $display("%0t: root of %h, expected %h, actual %h",
                   $realtime, want.radicand, want.root, out_tdata);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // present one radicand and hold it until the input transaction; valid
  // stays high so a following radicand goes out back to back
  task automatic send_radicand(input logic [VALUE_WIDTH-1:0] radicand);
    root_pair_t pending;
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(radicand);
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    pending.radicand = radicand;
    pending.root     = newton_root(radicand, current_iterations);
    expected_roots.push_back(pending);
    items_sent++;
  endtask

  // sender gap; a zero gap leaves valid alone for a back-to-back transaction
  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding root
  task automatic drain_roots();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_roots.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // iteration count only changes with the block idle
  task automatic set_iteration_count(input logic [ITER_W-1:0] iterations);
    drain_roots();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= iterations;
    @(posedge clk);
    cfg_we    <= 1'b0;
    current_iterations = iterations;
  endtask

  // radicand mix: full range, shrunk magnitudes, powers of two and their
  // neighbours, exact squares, near full scale and tiny values
  function automatic logic [VALUE_WIDTH-1:0] pick_radicand();
    logic [31:0] raw;
    logic [15:0] side;
    raw  = $urandom;
    side = 16'($urandom);
    case ($urandom_range(0, 7))
      0, 1, 2: return raw;
      3:       return raw >> $urandom_range(1, 31);
      4:       return (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
      5:       return 32'(side) * 32'(side);
      6:       return raw | 32'hFFFF_0000;
      default: return 32'($urandom_range(0, 3));
    endcase
  endfunction

  // reset default of 10 iterations, never written
  task automatic test_reset_count();
    send_radicand(32'h0000_0000);   // zero radicand, no division
    send_radicand(32'h0000_0001);   // start guess raised to one lsb
    send_radicand(32'h0000_0002);
    send_radicand(32'h0000_0003);
    send_radicand(32'h0001_0000);   // 1.0
    send_radicand(32'h0004_0000);   // 4.0, exact
    send_radicand(32'h0000_0100);
    send_radicand(32'h5555_5555);
    send_radicand(32'hAAAA_AAAA);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h8000_0000);
    send_radicand(32'hFFFF_FFFF);   // full scale
    drain_roots();
  endtask

  // zero count: the root is the start guess itself
  task automatic test_zero_iterations();
    set_iteration_count('0);
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0000_0005);
    send_radicand(32'hFFFF_FFFF);
    drain_roots();
  endtask

  // largest count, the slowest items of the run
  task automatic test_long_iterations();
    set_iteration_count(5'd31);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0001_0000);
    pause_sender(3);
    send_radicand(32'h0000_0000);
    drain_roots();
  endtask

  // a single iteration leaves the guess far from converged
  task automatic test_single_iteration();
    set_iteration_count(5'd1);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h0000_0002);
    send_radicand(32'h0009_0000);
    drain_roots();
  endtask

  // random radicands in bursts; halfway through the sender waits for
  // every outstanding root before going on
  task automatic test_random_radicands(input logic [ITER_W-1:0] iterations,
                                       input int unsigned       count);
    int unsigned burst_left;
    set_iteration_count(iterations);
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain_roots();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
      end
      send_radicand(pick_radicand());
      burst_left--;
    end
    drain_roots();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_count();
    test_zero_iterations();
    test_long_iterations();
    test_single_iteration();

    // most items at the short counts, fewest at the longest
    test_random_radicands(5'd1,  300);
    test_random_radicands(5'd2,  220);
    test_random_radicands(5'd3,  180);
    test_random_radicands(5'd4,   80);
    test_random_radicands(5'd5,  140);
    test_random_radicands(5'd10, 110);
    test_random_radicands(5'd17,  60);
    test_random_radicands(5'd31,  40);

    drain_roots();
    repeat (8) @(posedge clk);

    $display("run covered %0d radicands: zero, one lsb, full scale and random values",
             items_sent);
    $display("iteration counts 0 to 31 incl. reset default, %0d roots compared, %0d failures",
             roots_checked, error_count);
    if (error_count == 0 && expected_roots.size() == 0) begin
      $display("newton_square_root: match");
    end else begin
      $display("newton_square_root: mismatch");
    end
    $finish;
  end

endmodule
